// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file i2a_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define I2A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2a check failed");

// next-cycle implication, disabled while reset is low
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2a check failed");

`endif

// ----- rtl/core/i2a_pkg.sv -----
// shared types, constants and character codes of the integer to ascii formatter
// no dependencies
`default_nettype none

package i2a_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int LIMIT          = 64;
  localparam int LEN_W          = 7;
  localparam int DIG_IDX_W      = 6;
  localparam int IN_TDATA_W     = 80;
  localparam int OUT_TDATA_W    = 8;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 7'd64;

  // register select bit of the word address
  localparam logic CFG_REG_MAX_LENGTH = 1'b0;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_NONE    = 8'h00;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef struct packed {
    logic                 load;
    logic                 shift;
    radix_t               radix;
    logic [DIG_IDX_W-1:0] idx;
  } dig_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/integer_to_ascii_formatter_unit.sv -----
// top level of the integer to ascii formatter: config register and the
// sequencer with its digit unit; uses i2a_pkg, i2a_seq, i2a_digit_unit
`default_nettype none

// An item is accepted, then for decimal converted by shift-add-3 in the
// digit unit, then scanned from the top digit down to the first nonzero
// one, laid out, and sent as output characters (up to max_length, capped
// at 64), which stall while out_tready is low.
// An error item (length limits inconsistent) skips the digits. in_tready is
// high only between items; the last character may still wait in the output
// register while the next item is taken. max_length sits at byte address 0
// and resets to 64; write it only while no item is in flight.
module integer_to_ascii_formatter_unit import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // value[63:0], is_signed, radix_select[1:0], upper_digits, force_plus,
  // left_align, zero_fill, min_width[6:0], two zero bits
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // char_out[7:0]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  // error
  output logic                        out_tuser,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic [LEN_W-1:0]      max_length_r;
  logic                  cfg_sel_len;
  dig_ctrl_t             dig_ctrl;
  logic [VALUE_BITS-1:0] load_mag;
  logic [3:0]            digit;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_len = (cfg_paddr[CFG_ADDR_W-1] == CFG_REG_MAX_LENGTH);
  assign cfg_prdata  = cfg_sel_len ? {{(CFG_DATA_W-LEN_W){1'b0}}, max_length_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_len) begin
      max_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  i2a_seq #(
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .max_length (max_length_r),
    .dig_ctrl   (dig_ctrl),
    .load_mag   (load_mag),
    .digit      (digit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  i2a_digit_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit (
    .clk      (clk),
    .ctrl     (dig_ctrl),
    .load_mag (load_mag),
    .digit    (digit)
  );

endmodule

`default_nettype wire

// ----- rtl/core/i2a_digit_unit.sv -----
// digit store: loads the magnitude, runs the shift-add-3 decimal conversion
// one bit per cycle and reads out any digit by index; uses i2a_pkg
`default_nettype none

module i2a_digit_unit import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire dig_ctrl_t             ctrl,
  input  wire logic [VALUE_BITS-1:0] load_mag,
  output logic      [3:0]            digit
);

  localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BUF_W      = 4 * BCD_DIGITS;
  localparam int AMT_W      = DIG_IDX_W + 2;

  logic [BUF_W-1:0]      buf_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic [BUF_W-1:0]      adj;
  logic [AMT_W-1:0]      amt;
  logic [BUF_W-1:0]      sh;
  logic [3:0]            mask;

  // add 3 to every bcd digit of 5 or more before the shift
  for (genvar g = 0; g < BCD_DIGITS; g++) begin : g_adj
    assign adj[4*g +: 4] = (buf_r[4*g +: 4] >= 4'd5) ? buf_r[4*g +: 4] + 4'd3
                                                      : buf_r[4*g +: 4];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r <= load_mag;
      if (ctrl.radix == RADIX_DEC) begin
        buf_r <= '0;
      end else begin
        buf_r <= {{(BUF_W-VALUE_BITS){1'b0}}, load_mag};
      end
    end else if (ctrl.shift) begin
      buf_r <= {adj[BUF_W-2:0], mag_r[VALUE_BITS-1]};
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    case (ctrl.radix)
      RADIX_BIN: begin
        amt  = {2'b00, ctrl.idx};
        mask = 4'h1;
      end
      RADIX_OCT: begin
        amt  = {2'b00, ctrl.idx} + {1'b0, ctrl.idx, 1'b0};
        mask = 4'h7;
      end
      default: begin
        amt  = {ctrl.idx, 2'b00};
        mask = 4'hf;
      end
    endcase
    sh    = buf_r >> amt;
    digit = sh[3:0] & mask;
  end

endmodule

`default_nettype wire

// ----- rtl/core/i2a_seq.sv -----
// sequencer: item decode, length checks, digit count, layout and the
// character output register; drives i2a_digit_unit; uses i2a_pkg
`default_nettype none

module i2a_seq import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [LEN_W-1:0]       max_length,
  output dig_ctrl_t                   dig_ctrl,
  output logic      [VALUE_BITS-1:0]  load_mag,
  input  wire logic [3:0]             digit,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam logic [DIG_IDX_W-1:0] TOP_BIN = DIG_IDX_W'(VALUE_BITS - 1);
  localparam logic [DIG_IDX_W-1:0] TOP_OCT = DIG_IDX_W'((VALUE_BITS + 2) / 3 - 1);
  localparam logic [DIG_IDX_W-1:0] TOP_DEC = DIG_IDX_W'(BCD_DIGITS - 1);
  localparam logic [DIG_IDX_W-1:0] TOP_HEX = DIG_IDX_W'((VALUE_BITS + 3) / 4 - 1);
  localparam logic [CNT_W-1:0]     CNT_END = CNT_W'(VALUE_BITS - 1);
  localparam logic [LEN_W-1:0]     LEN_CAP = LEN_W'(LIMIT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_SCAN = 6'b000100,
    S_PLAN = 6'b001000,
    S_EMIT = 6'b010000,
    S_ERR  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   sign_r, sign_nxt;
  logic [7:0]             sign_char_r, sign_char_nxt;
  logic                   upper_r, upper_nxt;
  logic                   left_r, left_nxt;
  logic                   zfill_r, zfill_nxt;
  radix_t                 radix_r, radix_nxt;
  logic [LEN_W-1:0]       minw_r, minw_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0]   idx_r, idx_nxt;
  logic [LEN_W-1:0]       nd_r, nd_nxt;
  logic [LEN_W-1:0]       lead_end_r, lead_end_nxt;
  logic [LEN_W-1:0]       dig_start_r, dig_start_nxt;
  logic [LEN_W-1:0]       dig_end_r, dig_end_nxt;
  logic [LEN_W-1:0]       last_pos_r, last_pos_nxt;
  logic [LEN_W-1:0]       pos_r, pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_err_r, out_err_nxt;

  logic [VALUE_BITS-1:0]  v_in;
  logic                   neg_in, plus_in, s_in, err_in, accept;
  radix_t                 radix_in;
  logic [LEN_W-1:0]       minw_in, maxl, room, nsig, width, pad;
  logic [LEN_W-1:0]       dig_off;
  logic                   slot_free, in_digits;
  logic [7:0]             dig_char, emit_char, fill_char;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // item fields
  assign v_in     = in_tdata[VALUE_BITS-1:0];
  assign radix_in = radix_t'(in_tdata[66:65]);
  assign plus_in  = in_tdata[68];
  assign minw_in  = in_tdata[77:71];
  assign neg_in   = in_tdata[64] && v_in[VALUE_BITS-1];
  assign s_in     = neg_in || plus_in;
  assign load_mag = neg_in ? (~v_in) + VALUE_BITS'(1) : v_in;

  assign maxl   = (max_length > LEN_CAP) ? LEN_CAP : max_length;
  assign err_in = (maxl < (LEN_W'(1) + LEN_W'(s_in))) || (minw_in > maxl);
  assign room   = maxl - LEN_W'(sign_r);
  assign nsig   = LEN_W'(idx_r) + LEN_W'(1);
  assign width  = nd_r + LEN_W'(sign_r);
  assign pad    = (minw_r > width) ? minw_r - width : '0;

  assign dig_off        = dig_end_r - pos_r;
  assign dig_ctrl.load  = accept && !err_in;
  assign dig_ctrl.shift = (state_r == S_CONV);
  assign dig_ctrl.radix = accept ? radix_in : radix_r;
  assign dig_ctrl.idx   = (state_r == S_EMIT) ? dig_off[DIG_IDX_W-1:0] : idx_r;

  assign slot_free = !out_valid_r || out_tready;
  assign in_digits = (pos_r >= dig_start_r) && (pos_r <= dig_end_r);
  assign fill_char = zfill_r ? CH_ZERO : CH_SPACE;

  always_comb begin
    if (digit >= DIGIT_TEN) begin
      dig_char = (upper_r ? CH_UPPER_A : CH_LOWER_A) + {4'd0, digit - DIGIT_TEN};
    end else begin
      dig_char = CH_ZERO + {4'd0, digit};
    end
    if (sign_r && (pos_r == lead_end_r)) begin
      emit_char = sign_char_r;
    end else if (in_digits) begin
      emit_char = dig_char;
    end else begin
      emit_char = fill_char;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sign_nxt      = sign_r;
    sign_char_nxt = sign_char_r;
    upper_nxt     = upper_r;
    left_nxt      = left_r;
    zfill_nxt     = zfill_r;
    radix_nxt     = radix_r;
    minw_nxt      = minw_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    nd_nxt        = nd_r;
    lead_end_nxt  = lead_end_r;
    dig_start_nxt = dig_start_r;
    dig_end_nxt   = dig_end_r;
    last_pos_nxt  = last_pos_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sign_nxt      = s_in;
          sign_char_nxt = neg_in ? CH_MINUS : CH_PLUS;
          upper_nxt     = in_tdata[67];
          left_nxt      = in_tdata[69];
          zfill_nxt     = in_tdata[70];
          radix_nxt     = radix_in;
          minw_nxt      = minw_in;
          cnt_nxt       = '0;
          case (radix_in)
            RADIX_BIN: idx_nxt = TOP_BIN;
            RADIX_OCT: idx_nxt = TOP_OCT;
            RADIX_DEC: idx_nxt = TOP_DEC;
            default:   idx_nxt = TOP_HEX;
          endcase
          if (err_in) begin
            state_nxt = S_ERR;
          end else if (radix_in == RADIX_DEC) begin
            state_nxt = S_CONV;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_CONV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_END) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // highest nonzero digit, or a single zero
        if ((digit != 4'd0) || (idx_r == '0)) begin
          nd_nxt    = (nsig < room) ? nsig : room;
          state_nxt = S_PLAN;
        end else begin
          idx_nxt = idx_r - DIG_IDX_W'(1);
        end
      end
      S_PLAN: begin
        lead_end_nxt  = (!left_r && !zfill_r) ? pad : '0;
        dig_start_nxt = ((!left_r && !zfill_r) ? pad : '0) + LEN_W'(sign_r)
                        + ((!left_r && zfill_r) ? pad : '0);
        dig_end_nxt   = ((!left_r && !zfill_r) ? pad : '0) + LEN_W'(sign_r)
                        + ((!left_r && zfill_r) ? pad : '0) + nd_r - LEN_W'(1);
        last_pos_nxt  = pad + width - LEN_W'(1);
        pos_nxt       = '0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = emit_char;
          out_last_nxt  = (pos_r == last_pos_r);
          out_err_nxt   = 1'b0;
          pos_nxt       = pos_r + LEN_W'(1);
          if (pos_r == last_pos_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_NONE;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r      <= sign_nxt;
    sign_char_r <= sign_char_nxt;
    upper_r     <= upper_nxt;
    left_r      <= left_nxt;
    zfill_r     <= zfill_nxt;
    radix_r     <= radix_nxt;
    minw_r      <= minw_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    nd_r        <= nd_nxt;
    lead_end_r  <= lead_end_nxt;
    dig_start_r <= dig_start_nxt;
    dig_end_r   <= dig_end_nxt;
    last_pos_r  <= last_pos_nxt;
    pos_r       <= pos_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

`default_nettype wire

// ----- rtl/core/i2a_checker.sv -----
// port-level checks of the integer to ascii formatter and their bind
// uses assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module i2a_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // stalled output item holds
  `I2A_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // error item is a lone zero character marked last
  `I2A_ASSERT_NOW(a_err_form, clk, rst_n, out_tvalid && out_tuser,
    out_tlast && (out_tdata == 8'h00))

  // no new item while a character run is unfinished
  `I2A_ASSERT_NOW(a_run_busy, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // an accepted item keeps the block busy the next cycle
  `I2A_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // characters are printable
  `I2A_ASSERT_NOW(a_printable, clk, rst_n, out_tvalid && !out_tuser,
    (out_tdata >= 8'h20) && (out_tdata <= 8'h7a))

endmodule

bind integer_to_ascii_formatter_unit i2a_checker u_i2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
